// ===== rtl/core/hbc_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// hbc_pkg
// Shared types and constants for the half / bfloat16 / bool converter pipeline.
// ----------------------------------------------------------------------------
package hbc_pkg;

	// conversion kinds
	typedef logic [1:0] kind_t;
	localparam kind_t KIND_H2B    = 2'd0;
	localparam kind_t KIND_B2H    = 2'd1;
	localparam kind_t KIND_B2BOOL = 2'd2;
	localparam kind_t KIND_BOOL2B = 2'd3;

	// format constants
	localparam logic [15:0] BF16_ONE      = 16'h3F80;
	localparam logic [15:0] BF16_QNAN     = 16'h7FC0;
	localparam logic [15:0] HALF_INF      = 16'h7C00;
	localparam logic [15:0] HALF_QUIET    = 16'h0200;
	localparam logic [7:0]  HALF_TO_BF_BIAS = 8'd112;
	localparam logic [7:0]  SUB_EXP_BASE    = 8'd113;
	localparam logic [7:0]  B2H_EXP_LOW     = 8'd112;
	localparam logic [7:0]  B2H_EXP_HIGH    = 8'd143;

	// stage 1 word: decoded fields and leading-zero count
	typedef struct packed {
		kind_t       kind;
		logic [15:0] value;
		logic        last;
		logic [3:0]  lz;
		logic        h_exp_max;
		logic        h_exp_zero;
		logic        h_man_zero;
	} s1_t;

	// stage 2 word: pre-round bf16 and the other kinds' results
	typedef struct packed {
		kind_t       kind;
		logic        last;
		logic [15:0] upper;
		logic        round_up;
		logic [15:0] alt;
	} s2_t;

endpackage

// ===== rtl/core/hbc_decode.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// hbc_decode
// Stage 1: splits the half fields, classifies them and counts leading zeros.
// ----------------------------------------------------------------------------
module hbc_decode import hbc_pkg::*; (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        in_valid,
	input  kind_t       kind,
	input  logic [15:0] value_in,
	input  logic        last_in,
	output logic        valid_s1,
	output s1_t         word_s1
);

	logic [9:0] man;
	logic [3:0] lz;
	s1_t        nxt;

	assign man = value_in[9:0];

	// leading zeros of the half mantissa up to the implicit bit position
	always_comb begin
		lz = 4'd0;
		for (int i = 0; i < 10; i++) begin
			if (man[i]) begin
				lz = 4'(10 - i);
			end
		end
	end

	always_comb begin
		nxt.kind       = kind;
		nxt.value      = value_in;
		nxt.last       = last_in;
		nxt.lz         = lz;
		nxt.h_exp_max  = &value_in[14:10];
		nxt.h_exp_zero = ~|value_in[14:10];
		nxt.h_man_zero = ~|man;
	end

	// valid bit
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else begin
			valid_s1 <= in_valid;
		end
	end

	// payload
	always_ff @(posedge clk) begin
		word_s1 <= nxt;
	end

endmodule

// ===== rtl/core/hbc_normalize.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// hbc_normalize
// Stage 2: widens the half to bf16 fields before rounding, and forms the
// bf16-to-half and bool results.
// ----------------------------------------------------------------------------
module hbc_normalize import hbc_pkg::*; (
	input  logic clk,
	input  logic arst_n,
	input  logic valid_s1,
	input  s1_t  word_s1,
	output logic valid_s2,
	output s2_t  word_s2
);

	logic        sgn;
	logic [9:0]  hman;
	logic [9:0]  shifted;
	logic [7:0]  wexp;
	logic [9:0]  wman;
	logic [7:0]  bexp;
	logic [6:0]  bman;
	logic [4:0]  hexp_wide;
	logic [15:0] b2h;
	s2_t         nxt;

	assign sgn  = word_s1.value[15];
	assign hman = word_s1.value[9:0];
	// the implicit bit shifts out of the top
	assign shifted = hman << word_s1.lz;

	// half to single-precision exponent and mantissa
	always_comb begin
		if (word_s1.h_exp_max) begin
			wexp = 8'hFF;
			wman = 10'd0;
		end else if (word_s1.h_exp_zero) begin
			if (word_s1.h_man_zero) begin
				wexp = 8'd0;
				wman = 10'd0;
			end else begin
				wexp = SUB_EXP_BASE - {4'd0, word_s1.lz};
				wman = shifted;
			end
		end else begin
			wexp = {3'd0, word_s1.value[14:10]} + HALF_TO_BF_BIAS;
			wman = hman;
		end
	end

	// bf16 to half with truncation, flush, saturation and nan quieting
	assign bexp      = word_s1.value[14:7];
	assign bman      = word_s1.value[6:0];
	assign hexp_wide = 5'(bexp - B2H_EXP_LOW);
	always_comb begin
		if (bexp == 8'hFF) begin
			b2h = {sgn, 15'd0} | HALF_INF | ((bman != 7'd0) ? HALF_QUIET : 16'd0);
		end else if (bexp <= B2H_EXP_LOW) begin
			b2h = {sgn, 15'd0};
		end else if (bexp >= B2H_EXP_HIGH) begin
			b2h = {sgn, 15'd0} | HALF_INF;
		end else begin
			b2h = {sgn, hexp_wide, bman, 3'd0};
		end
	end

	always_comb begin
		nxt.kind = word_s1.kind;
		nxt.last = word_s1.last;
		// nan input becomes a quiet bf16 nan, never rounded
		if (word_s1.h_exp_max && !word_s1.h_man_zero) begin
			nxt.upper    = {sgn, 15'd0} | BF16_QNAN;
			nxt.round_up = 1'b0;
		end else begin
			nxt.upper    = {sgn, wexp, wman[9:3]};
			// nearest even on the dropped bits wman[2:0]
			nxt.round_up = wman[2] & (wman[1] | wman[0] | wman[3]);
		end
		case (word_s1.kind)
			KIND_B2H:    nxt.alt = b2h;
			KIND_B2BOOL: nxt.alt = {15'd0, |word_s1.value};
			KIND_BOOL2B: nxt.alt = word_s1.value[0] ? BF16_ONE : 16'd0;
			default:     nxt.alt = 16'd0;
		endcase
	end

	// valid bit
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s2 <= 1'b0;
		end else begin
			valid_s2 <= valid_s1;
		end
	end

	// payload
	always_ff @(posedge clk) begin
		word_s2 <= nxt;
	end

endmodule

// ===== rtl/core/hbc_round.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// hbc_round
// Stage 3: applies the rounding increment and selects the result word.
// ----------------------------------------------------------------------------
module hbc_round import hbc_pkg::*; (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        valid_s2,
	input  s2_t         word_s2,
	output logic        valid_s3,
	output logic [15:0] value_s3,
	output logic        last_s3
);

	logic [15:0] rounded;
	logic [15:0] result;

	// increment carries into the exponent as needed
	assign rounded = word_s2.upper + {15'd0, word_s2.round_up};
	assign result  = (word_s2.kind == KIND_H2B) ? rounded : word_s2.alt;

	// valid bit
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s3 <= 1'b0;
		end else begin
			valid_s3 <= valid_s2;
		end
	end

	// payload
	always_ff @(posedge clk) begin
		value_s3 <= result;
		last_s3  <= word_s2.last;
	end

endmodule

// ===== rtl/core/half_bfloat16_converter_unit.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// half_bfloat16_converter_unit
// Elementwise converter between half, bfloat16 and bool, three stages deep.
//
// channel  | ports                          | handshake
// ---------+--------------------------------+------------------------------
// input    | kind, value_in, last_in        | start high, busy low
// result   | value_out, last_out            | done high for one cycle
//
// One word enters per cycle; its result leaves with done once it has passed
// the three pipeline registers: decode and leading-zero count, normalize,
// round and select.
// busy is held low: the receiver cannot stall, so the pipeline always moves.
// Reset clears the valid bits only; no word is in flight after reset.
// ----------------------------------------------------------------------------
module half_bfloat16_converter_unit import hbc_pkg::*; (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        start,
	output logic        busy,
	input  kind_t       kind,
	input  logic [15:0] value_in,
	input  logic        last_in,
	output logic        done,
	output logic [15:0] value_out,
	output logic        last_out
);

	logic valid_s1;
	logic valid_s2;
	s1_t  word_s1;
	s2_t  word_s2;

	// never stalls
	assign busy = 1'b0;

	hbc_decode u_decode (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (start),
		.kind     (kind),
		.value_in (value_in),
		.last_in  (last_in),
		.valid_s1 (valid_s1),
		.word_s1  (word_s1)
	);

	hbc_normalize u_normalize (
		.clk      (clk),
		.arst_n   (arst_n),
		.valid_s1 (valid_s1),
		.word_s1  (word_s1),
		.valid_s2 (valid_s2),
		.word_s2  (word_s2)
	);

	hbc_round u_round (
		.clk      (clk),
		.arst_n   (arst_n),
		.valid_s2 (valid_s2),
		.word_s2  (word_s2),
		.valid_s3 (done),
		.value_s3 (value_out),
		.last_s3  (last_out)
	);

`ifndef SYNTHESIS
	// a result only follows an accepted word
	a_done_follows_start: assert property (@(posedge clk) disable iff (!arst_n)
		done |-> $past(start, 3))
		else $error("result without accepted word");

	// last marker travels with its word
	a_last_aligned: assert property (@(posedge clk) disable iff (!arst_n)
		done |-> (last_out == $past(last_in, 3)))
		else $error("last_out misaligned");

	// bool results use bit 0 only
	a_bool_out: assert property (@(posedge clk) disable iff (!arst_n)
		(done && $past(kind, 3) == KIND_B2BOOL) |-> (value_out[15:1] == 15'd0))
		else $error("bool result has upper bits set");

	// bool to bf16 gives zero or one
	a_bool_in: assert property (@(posedge clk) disable iff (!arst_n)
		(done && $past(kind, 3) == KIND_BOOL2B) |->
		(value_out == 16'd0 || value_out == BF16_ONE))
		else $error("bool to bf16 out of set");
`endif

endmodule
